// ===== rtl/bmef_pkg.sv =====
// Shared constants, command/status structs and codes for the batch median
// and moving-average filter. No dependencies; used by every file in rtl/.
package bmef_pkg;

    // Batch and sample geometry
    localparam int unsigned BATCH_SIZE  = 7;
    localparam int unsigned SAMPLE_BITS = 16;
    localparam int unsigned IDX_W       = $clog2(BATCH_SIZE);
    localparam int unsigned CNT_W       = $clog2(BATCH_SIZE + 1);
    localparam int unsigned MID_RANK    = BATCH_SIZE / 2;

    // Port field widths
    localparam int unsigned IN_W        = 16;
    localparam int unsigned PPM_W       = 16;
    localparam int unsigned FILL_OUT_W  = 3;
    localparam int unsigned S_TDATA_W   = 16;
    localparam int unsigned M_TDATA_W   = 24;
    localparam int unsigned M_TUSER_W   = 2;
    localparam int unsigned TDATA_PAD_W = M_TDATA_W - PPM_W - FILL_OUT_W;

    // Arithmetic widths: average in milli-units, update accumulator, shared multiplier
    localparam int unsigned AVG_W       = 26;
    localparam int unsigned ACC_W       = 30;
    localparam int unsigned MUL_B_W     = 31;
    localparam int unsigned PROD_W      = ACC_W + MUL_B_W;

    localparam int unsigned MILLI_SCALE = 1000;
    localparam int unsigned UPD_ROUND   = 5;
    localparam int unsigned OUT_ROUND   = 500;

    // Reciprocals: floor(x/10) = (x*RECIP10) >> 34 for x < 2^30,
    // floor(x/1000) = (x*RECIP1000) >> 36 for x < 2^26.
    localparam int unsigned RECIP10         = 1717986919;
    localparam int unsigned RECIP10_SHIFT   = 34;
    localparam int unsigned RECIP1000       = 68719477;
    localparam int unsigned RECIP1000_SHIFT = 36;

    // Multiplier operand select codes
    localparam logic [1:0] MUL_SEL_MILLI = 2'd0;
    localparam logic [1:0] MUL_SEL_DIV10 = 2'd1;
    localparam logic [1:0] MUL_SEL_DIV1K = 2'd2;

    typedef struct packed {
        logic       store_we;   // write sample, advance fill count
        logic       scan_step;  // test one median candidate
        logic       mul_en;     // load product register
        logic [1:0] mul_sel;    // operand pair for the multiplier
        logic       avg_seed;   // seed average from scaled median
        logic       acc_init;   // acc = 3*scaled median + 5
        logic       acc_add;    // acc += 7*average
        logic       avg_div;    // average = acc / 10
        logic       rnd_load;   // acc = average + 500
        logic       ppm_load;   // rounded ppm = acc / 1000
        logic       out_load;   // capture result into output register
    } bmef_cmd_t;

    typedef struct packed {
        logic last;    // incoming sample completes the batch
        logic found;   // current candidate is the median
        logic seeded;  // average has been seeded
    } bmef_status_t;

endpackage

// ===== rtl/bmef_dp.sv =====
// Datapath of the batch median filter: sample store, median scan, shared
// multiplier, average and output registers. Depends on bmef_pkg.
module bmef_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [bmef_pkg::IN_W-1:0]           sample,
    input  bmef_pkg::bmef_cmd_t                 cmd,
    output bmef_pkg::bmef_status_t              status,
    output logic [bmef_pkg::PPM_W-1:0]          out_ppm,
    output logic                                out_valid_flag,
    output logic                                out_done,
    output logic [bmef_pkg::FILL_OUT_W-1:0]     out_fill
);

    logic [bmef_pkg::SAMPLE_BITS-1:0] store_reg [bmef_pkg::BATCH_SIZE];
    logic [bmef_pkg::IDX_W-1:0]       fill_reg;
    logic                             done_reg;
    logic                             seeded_reg;
    logic [bmef_pkg::IDX_W-1:0]       scan_idx_reg;
    logic [bmef_pkg::SAMPLE_BITS-1:0] med_reg;
    logic [bmef_pkg::PROD_W-1:0]      prod_reg;
    logic [bmef_pkg::ACC_W-1:0]       acc_reg;
    logic [bmef_pkg::AVG_W-1:0]       avg_reg;
    logic [bmef_pkg::PPM_W-1:0]       ppm_reg;

    logic [bmef_pkg::PPM_W-1:0]       out_ppm_reg;
    logic                             out_valid_reg;
    logic                             out_done_reg;
    logic [bmef_pkg::FILL_OUT_W-1:0]  out_fill_reg;

    logic [bmef_pkg::SAMPLE_BITS-1:0] cand;
    logic [bmef_pkg::CNT_W-1:0]       lt_cnt;
    logic [bmef_pkg::CNT_W-1:0]       le_cnt;
    logic                             match;
    logic [bmef_pkg::ACC_W-1:0]       mul_a;
    logic [bmef_pkg::MUL_B_W-1:0]     mul_b;
    logic [bmef_pkg::AVG_W-1:0]       med_milli;
    logic [bmef_pkg::CNT_W-1:0]       shown;
    logic                             last;

    assign last = (fill_reg == bmef_pkg::IDX_W'(bmef_pkg::BATCH_SIZE - 1));

    // Rank test of one candidate against the whole batch
    assign cand = store_reg[scan_idx_reg];
    always_comb begin
        lt_cnt = '0;
        le_cnt = '0;
        for (int j = 0; j < bmef_pkg::BATCH_SIZE; j++) begin
            lt_cnt = lt_cnt + bmef_pkg::CNT_W'(store_reg[j] <  cand);
            le_cnt = le_cnt + bmef_pkg::CNT_W'(store_reg[j] <= cand);
        end
    end
    assign match = (lt_cnt <= bmef_pkg::CNT_W'(bmef_pkg::MID_RANK)) &&
                   (le_cnt >  bmef_pkg::CNT_W'(bmef_pkg::MID_RANK));

    // Shared multiplier operands
    always_comb begin
        unique case (cmd.mul_sel)
            bmef_pkg::MUL_SEL_MILLI: begin
                mul_a = bmef_pkg::ACC_W'(med_reg);
                mul_b = bmef_pkg::MUL_B_W'(bmef_pkg::MILLI_SCALE);
            end
            bmef_pkg::MUL_SEL_DIV10: begin
                mul_a = acc_reg;
                mul_b = bmef_pkg::MUL_B_W'(bmef_pkg::RECIP10);
            end
            bmef_pkg::MUL_SEL_DIV1K: begin
                mul_a = acc_reg;
                mul_b = bmef_pkg::MUL_B_W'(bmef_pkg::RECIP1000);
            end
            default: begin
                mul_a = acc_reg;
                mul_b = '0;
            end
        endcase
    end

    assign med_milli = prod_reg[bmef_pkg::AVG_W-1:0];
    assign shown     = done_reg ? bmef_pkg::CNT_W'(bmef_pkg::BATCH_SIZE)
                                : bmef_pkg::CNT_W'(fill_reg);

    // Sample store: written only, no reset
    always_ff @(posedge aclk) begin
        if (cmd.store_we) begin
            store_reg[fill_reg] <= sample[bmef_pkg::SAMPLE_BITS-1:0];
        end
    end

    // Control-visible state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            done_reg     <= 1'b0;
            seeded_reg   <= 1'b0;
            scan_idx_reg <= '0;
            avg_reg      <= '0;
            ppm_reg      <= '0;
        end else begin
            if (cmd.store_we) begin
                scan_idx_reg <= '0;
                done_reg     <= last;
                fill_reg     <= last ? '0 : fill_reg + bmef_pkg::IDX_W'(1);
            end
            if (cmd.scan_step) begin
                scan_idx_reg <= scan_idx_reg + bmef_pkg::IDX_W'(1);
            end
            if (cmd.avg_seed) begin
                avg_reg    <= med_milli;
                seeded_reg <= 1'b1;
            end
            if (cmd.avg_div) begin
                avg_reg <= prod_reg[bmef_pkg::RECIP10_SHIFT +: bmef_pkg::AVG_W];
            end
            if (cmd.ppm_load) begin
                ppm_reg <= prod_reg[bmef_pkg::RECIP1000_SHIFT +: bmef_pkg::PPM_W];
            end
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        if (cmd.scan_step && match) begin
            med_reg <= cand;
        end
        if (cmd.mul_en) begin
            prod_reg <= bmef_pkg::PROD_W'(mul_a) * bmef_pkg::PROD_W'(mul_b);
        end
        if (cmd.acc_init) begin
            acc_reg <= bmef_pkg::ACC_W'({med_milli, 1'b0}) + bmef_pkg::ACC_W'(med_milli)
                     + bmef_pkg::ACC_W'(bmef_pkg::UPD_ROUND);
        end else if (cmd.acc_add) begin
            acc_reg <= acc_reg + bmef_pkg::ACC_W'({avg_reg, 3'b000})
                     - bmef_pkg::ACC_W'(avg_reg);
        end else if (cmd.rnd_load) begin
            acc_reg <= bmef_pkg::ACC_W'(avg_reg) + bmef_pkg::ACC_W'(bmef_pkg::OUT_ROUND);
        end
        if (cmd.out_load) begin
            out_ppm_reg   <= ppm_reg;
            out_valid_reg <= seeded_reg;
            out_done_reg  <= done_reg;
            out_fill_reg  <= bmef_pkg::FILL_OUT_W'(shown);
        end
    end

    assign status.last   = last;
    assign status.found  = match;
    assign status.seeded = seeded_reg;

    assign out_ppm        = out_ppm_reg;
    assign out_valid_flag = out_valid_reg;
    assign out_done       = out_done_reg;
    assign out_fill       = out_fill_reg;

endmodule

// ===== rtl/bmef_ctrl.sv =====
// Sequencer of the batch median filter: handshakes and datapath commands.
// Depends on bmef_pkg.
module bmef_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  bmef_pkg::bmef_status_t status,
    output bmef_pkg::bmef_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SCAN  = 4'd1;
    localparam logic [3:0] ST_SCALE = 4'd2;
    localparam logic [3:0] ST_UPD   = 4'd3;
    localparam logic [3:0] ST_ACC   = 4'd4;
    localparam logic [3:0] ST_DIV   = 4'd5;
    localparam logic [3:0] ST_AVG   = 4'd6;
    localparam logic [3:0] ST_ROUND = 4'd7;
    localparam logic [3:0] ST_MULR  = 4'd8;
    localparam logic [3:0] ST_PPM   = 4'd9;
    localparam logic [3:0] ST_PUSH  = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       m_tvalid_reg;
    logic       m_tvalid_next;
    logic       out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = bmef_pkg::MUL_SEL_MILLI;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.store_we = 1'b1;
                    state_next   = status.last ? ST_SCAN : ST_PUSH;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.found) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = bmef_pkg::MUL_SEL_MILLI;
                state_next  = ST_UPD;
            end
            ST_UPD: begin
                if (status.seeded) begin
                    cmd.acc_init = 1'b1;
                    state_next   = ST_ACC;
                end else begin
                    cmd.avg_seed = 1'b1;
                    state_next   = ST_ROUND;
                end
            end
            ST_ACC: begin
                cmd.acc_add = 1'b1;
                state_next  = ST_DIV;
            end
            ST_DIV: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = bmef_pkg::MUL_SEL_DIV10;
                state_next  = ST_AVG;
            end
            ST_AVG: begin
                cmd.avg_div = 1'b1;
                state_next  = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.rnd_load = 1'b1;
                state_next   = ST_MULR;
            end
            ST_MULR: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = bmef_pkg::MUL_SEL_DIV1K;
                state_next  = ST_PPM;
            end
            ST_PPM: begin
                cmd.ppm_load = 1'b1;
                state_next   = ST_PUSH;
            end
            ST_PUSH: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ===== rtl/batch_median_ema_filter.sv =====
// Top level of the batch median / moving-average filter: ties the sequencer
// to the datapath. Depends on bmef_pkg, bmef_ctrl and bmef_dp.
//
//  Channel  Dir  Handshake          Payload
//  -------  ---  -----------------  ---------------------------------------------
//  s_       in   s_tvalid/s_tready  s_tdata[15:0] raw_ppm
//  m_       out  m_tvalid/m_tready  m_tdata: filtered_ppm, fill_count
//                                   m_tuser: filtered_valid, batch_done
//
// A sample that does not complete a batch is accepted, then loaded as the
// result once the output register is free. The sample that completes a
// batch runs the median scan, one rank test per cycle over the stored
// entries, then the shared 30x31 multiplier sequence: scale, seed the
// average (first batch) or update and divide it (once seeded), then round.
// Reset (aresetn low, synchronous) clears fill count, average and flags;
// the sample store holds no reset value and is always written before use.
// The result waits in the output register while the next sample is taken;
// a new result is held back only while the previous one is still unaccepted.
module batch_median_ema_filter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bmef_pkg::S_TDATA_W-1:0]    s_tdata,   // [15:0] raw_ppm
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bmef_pkg::M_TDATA_W-1:0]    m_tdata,   // [15:0] filtered_ppm,
                                                         // [18:16] fill_count
    output logic [bmef_pkg::M_TUSER_W-1:0]    m_tuser    // [0] filtered_valid,
                                                         // [1] batch_done
);

    bmef_pkg::bmef_cmd_t                 cmd;
    bmef_pkg::bmef_status_t              status;
    logic [bmef_pkg::PPM_W-1:0]          out_ppm;
    logic                                out_valid_flag;
    logic                                out_done;
    logic [bmef_pkg::FILL_OUT_W-1:0]     out_fill;

    // Sequencer: owns both handshakes, issues one command set per cycle
    bmef_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: store, median scan, average update, output register
    bmef_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .sample         (s_tdata[bmef_pkg::IN_W-1:0]),
        .cmd            (cmd),
        .status         (status),
        .out_ppm        (out_ppm),
        .out_valid_flag (out_valid_flag),
        .out_done       (out_done),
        .out_fill       (out_fill)
    );

    // Pack the result transaction, zero fill to whole bytes
    assign m_tdata = {{bmef_pkg::TDATA_PAD_W{1'b0}}, out_fill, out_ppm};
    assign m_tuser = {out_done, out_valid_flag};

endmodule
